FILE: src/lte_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the laws texture energy block
// no dependencies

package lte_pkg;

   // frame geometry, fixed by the beat field widths
   localparam int COORD_W    = 9;
   localparam int IMAGE_SIDE = 512;
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int PIX_W      = 8;
   localparam int ENERGY_W   = 28;
   localparam int NUM_MASKS  = 9;
   localparam int MASK_IDX_W = 4;
   localparam int WIN_CFG_W  = 6;
   localparam int RESP_W     = 14;
   localparam int DSQ_W      = 11;

   localparam logic [WIN_CFG_W-1:0] WIN_RESET = 6'd51;

   // request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // squared mask divisors, mask k = column vector k/3, row vector k%3
   localparam logic [NUM_MASKS-1:0][DSQ_W-1:0] MASK_DSQ = {
      11'd16, 11'd16, 11'd144,
      11'd16, 11'd16, 11'd144,
      11'd144, 11'd144, 11'd1296
   };

   typedef struct packed {
      logic               req_type;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   pixel;
   } req_beat_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] energy_0;
      logic [ENERGY_W-1:0] energy_1;
      logic [ENERGY_W-1:0] energy_2;
      logic [ENERGY_W-1:0] energy_3;
      logic [ENERGY_W-1:0] energy_4;
      logic [ENERGY_W-1:0] energy_5;
      logic [ENERGY_W-1:0] energy_6;
      logic [ENERGY_W-1:0] energy_7;
      logic [ENERGY_W-1:0] energy_8;
   } rsp_beat_type;

   // sequencer to window/accumulator controls
   typedef struct packed {
      logic clear;
      logic cap0;
      logic cap1;
      logic shift;
      logic calc;
      logic accum;
   } acc_ctl_type;

endpackage

FILE: src/lte_frame_mem.sv
`timescale 1ns / 1ps
// frame pixel store, one write port and one registered read port
// depends on lte_pkg

module lte_frame_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lte_pkg::ADDR_W-1:0] wr_addr,
   input  logic [lte_pkg::PIX_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [lte_pkg::ADDR_W-1:0] rd_addr,
   output logic [lte_pkg::PIX_W-1:0]  rd_data
);

   logic [lte_pkg::PIX_W-1:0] mem [0:(2**lte_pkg::ADDR_W)-1];
   logic [lte_pkg::PIX_W-1:0] rd_data_ff;

   // pixel write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lte_mask_acc.sv
`timescale 1ns / 1ps
// 3x3 pixel window, nine mask responses and their squared-sum accumulators
// depends on lte_pkg

module lte_mask_acc #(
   parameter int ACC_W = 36
) (
   input  logic                                       clock,
   input  lte_pkg::acc_ctl_type                       ctl,
   input  logic [lte_pkg::PIX_W-1:0]                  rd_data,
   output logic [lte_pkg::NUM_MASKS-1:0][ACC_W-1:0]   acc
);

   localparam int SQ_W = 2 * lte_pkg::RESP_W;

   logic [lte_pkg::PIX_W-1:0] win_ff [0:2][0:2];
   logic [lte_pkg::PIX_W-1:0] ncol0_ff;
   logic [lte_pkg::PIX_W-1:0] ncol1_ff;
   logic signed [lte_pkg::RESP_W-1:0] p     [0:2][0:2];
   logic signed [lte_pkg::RESP_W-1:0] h     [0:2][0:2];
   logic signed [lte_pkg::RESP_W-1:0] s_in  [0:lte_pkg::NUM_MASKS-1];
   logic signed [lte_pkg::RESP_W-1:0] s_ff  [0:lte_pkg::NUM_MASKS-1];
   logic signed [SQ_W-1:0]            sq    [0:lte_pkg::NUM_MASKS-1];
   logic [lte_pkg::NUM_MASKS-1:0][ACC_W-1:0] acc_ff;

   // column capture and window shift, new column enters on the right
   always_ff @(posedge clock) begin
      if (ctl.cap0) begin
         ncol0_ff <= rd_data;
      end
      if (ctl.cap1) begin
         ncol1_ff <= rd_data;
      end
      if (ctl.shift) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= ncol0_ff;
         win_ff[1][2] <= ncol1_ff;
         win_ff[2][2] <= rd_data;
      end
   end

   // separable filtering: along each row first, then down the columns
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p[i][j] = $signed({{(lte_pkg::RESP_W - lte_pkg::PIX_W){1'b0}}, win_ff[i][j]});
         end
         h[0][i] = p[i][0] + (p[i][1] <<< 1) + p[i][2];
         h[1][i] = p[i][2] - p[i][0];
         h[2][i] = (p[i][1] <<< 1) - p[i][0] - p[i][2];
      end
      for (int b = 0; b < 3; b++) begin
         s_in[b]     = h[b][0] + (h[b][1] <<< 1) + h[b][2];
         s_in[3 + b] = h[b][2] - h[b][0];
         s_in[6 + b] = (h[b][1] <<< 1) - h[b][0] - h[b][2];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctl.calc) begin
         for (int k = 0; k < lte_pkg::NUM_MASKS; k++) begin
            s_ff[k] <= s_in[k];
         end
      end
   end

   // squared responses at full product width
   always_comb begin
      for (int k = 0; k < lte_pkg::NUM_MASKS; k++) begin
         sq[k] = SQ_W'(s_ff[k]) * SQ_W'(s_ff[k]);
      end
   end

   // squared response accumulation
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.accum) begin
         for (int k = 0; k < lte_pkg::NUM_MASKS; k++) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'($unsigned(sq[k]));
         end
      end
   end

   assign acc = acc_ff;

endmodule

FILE: src/lte_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on nothing outside this file

module lte_divider #(
   parameter int NUM_W = 44,
   parameter int DEN_W = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         q_ff   <= {q_ff[NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

   // handshake checks
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("divider did not go busy after start");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

FILE: src/laws_texture_energy.sv
`timescale 1ns / 1ps
// top level of the laws texture energy block: sequencer, config and result register
// depends on lte_pkg, lte_frame_mem, lte_mask_acc, lte_divider

// A write beat stores one pixel and leaves the block idle, so a new beat can be
// taken the next cycle. A query walks the neighbourhood row by row through the
// single read port of the frame memory; the walk covers window_size rows and
// columns for odd sizes and one fewer for even ones. Each window row starts by
// loading three pixel columns; each further position then computes and
// accumulates the responses, after reading a new column of three pixels when the
// clamped center column moves. The nine serial divisions then run one by one.
// Queries on the last row or column skip the walk. The frame has no clearing
// pass and must be fully written before a query. req_stall is high while a query
// is in work; a finished result waits in the output register while writes are
// taken.

module laws_texture_energy #(
   parameter int MAX_WINDOW = 63
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lte_pkg::req_beat_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lte_pkg::rsp_beat_type                 rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [lte_pkg::WIN_CFG_W-1:0]         csr_wr_data
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int W2_W  = 2 * WIN_W;
   localparam int ACC_W = 24 + $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int NUM_W = ACC_W + 8;
   localparam int DEN_W = lte_pkg::DSQ_W + W2_W;
   localparam int SW    = lte_pkg::COORD_W + WIN_W + 1;
   localparam int CW    = lte_pkg::COORD_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ROW    = 4'd1;
   localparam logic [3:0] S_FETCH  = 4'd2;
   localparam logic [3:0] S_FWAIT  = 4'd3;
   localparam logic [3:0] S_CALC   = 4'd4;
   localparam logic [3:0] S_ACC    = 4'd5;
   localparam logic [3:0] S_DEN    = 4'd6;
   localparam logic [3:0] S_DSTART = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   localparam logic [CW-1:0] LAST = CW'(lte_pkg::IMAGE_SIDE - 1);

   function automatic logic [CW-1:0] clamp_coord(input logic signed [SW-1:0] v);
      logic [CW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(SW'(lte_pkg::IMAGE_SIDE - 1))) begin
         r = LAST;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   logic [3:0]                     state_ff, state_in;
   logic [lte_pkg::WIN_CFG_W-1:0]  win_cfg_ff;
   logic [CW-1:0]                  row_ff, row_in, col_ff, col_in;
   logic [WIN_W-1:0]               span_ff, span_in, mi_ff, mi_in, ni_ff, ni_in;
   logic [W2_W-1:0]                w2_ff, w2_in;
   logic [CW-1:0]                  rr_ff, rr_in, cc_ff, cc_in, fcol_ff, fcol_in;
   logic [1:0]                     fleft_ff, fleft_in, fk_ff, fk_in;
   logic [lte_pkg::MASK_IDX_W-1:0] mk_ff, mk_in;
   logic [DEN_W-1:0]               den_ff, den_in;
   logic [lte_pkg::NUM_MASKS-1:0][lte_pkg::ENERGY_W-1:0] res_ff;
   logic                           rsp_valid_ff;
   lte_pkg::rsp_beat_type          rsp_data_ff, rsp_beat;

   logic                           req_take, query_take, write_take;
   logic [WIN_W-1:0]               w_sat, span_max;
   logic [lte_pkg::WIN_CFG_W-1:0]  w6;
   logic [CW-1:0]                  next_cc;
   logic                           interior;
   logic                           rd_en;
   logic [lte_pkg::ADDR_W-1:0]     rd_addr;
   logic [lte_pkg::PIX_W-1:0]      rd_data;
   lte_pkg::acc_ctl_type           ctl;
   logic [lte_pkg::NUM_MASKS-1:0][ACC_W-1:0] acc;
   logic                           div_start, div_done;
   logic [NUM_W-1:0]               div_quot;
   logic                           out_load;

   // handshake decode
   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign query_take = req_take && (req_data.req_type == lte_pkg::REQ_QUERY);
   assign write_take = req_take && (req_data.req_type == lte_pkg::REQ_WRITE);

   // window size register
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff <= lte_pkg::WIN_RESET;
      end else if (csr_wr_en) begin
         win_cfg_ff <= csr_wr_data;
      end
   end

   // effective window size: zero reads as one, saturated at MAX_WINDOW
   always_comb begin
      w6 = (win_cfg_ff == '0) ? lte_pkg::WIN_CFG_W'(1) : win_cfg_ff;
      w_sat = (int'(w6) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : WIN_W'(w6);
   end

   // walk helpers
   assign span_max = WIN_W'({span_ff, 1'b0});
   assign next_cc  = clamp_coord($signed(SW'(col_ff)) - $signed(SW'(span_ff))
                                 + $signed(SW'(ni_ff)) + $signed(SW'(1)));
   assign interior = (rr_ff != '0) && (cc_ff != '0) && (rr_ff != LAST) && (cc_ff != LAST);
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      span_in  = span_ff;
      w2_in    = w2_ff;
      mi_in    = mi_ff;
      ni_in    = ni_ff;
      rr_in    = rr_ff;
      cc_in    = cc_ff;
      fcol_in  = fcol_ff;
      fleft_in = fleft_ff;
      fk_in    = fk_ff;
      mk_in    = mk_ff;
      den_in   = den_ff;
      ctl      = '0;
      rd_en    = 1'b0;
      rd_addr  = {CW'(rr_ff + CW'(fk_ff) - CW'(1)), fcol_ff};
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (query_take) begin
               row_in    = req_data.row;
               col_in    = req_data.col;
               span_in   = WIN_W'((w_sat - WIN_W'(1)) >> 1);
               w2_in     = W2_W'(w_sat) * W2_W'(w_sat);
               mi_in     = '0;
               mk_in     = '0;
               ctl.clear = 1'b1;
               if (req_data.row == LAST || req_data.col == LAST) begin
                  state_in = S_DEN;
               end else begin
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            rr_in    = clamp_coord($signed(SW'(row_ff)) - $signed(SW'(span_ff))
                                   + $signed(SW'(mi_ff)));
            cc_in    = clamp_coord($signed(SW'(col_ff)) - $signed(SW'(span_ff)));
            fcol_in  = cc_in - CW'(1);
            fleft_in = 2'd3;
            fk_in    = '0;
            ni_in    = '0;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            rd_en    = 1'b1;
            ctl.cap0 = (fk_ff == 2'd1);
            ctl.cap1 = (fk_ff == 2'd2);
            fk_in    = fk_ff + 2'd1;
            if (fk_ff == 2'd2) begin
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: begin
            ctl.shift = 1'b1;
            fleft_in  = fleft_ff - 2'd1;
            if (fleft_ff == 2'd1) begin
               state_in = S_CALC;
            end else begin
               fcol_in  = fcol_ff + CW'(1);
               fk_in    = '0;
               state_in = S_FETCH;
            end
         end
         S_CALC: begin
            ctl.calc = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            ctl.accum = interior;
            if (ni_ff == span_max) begin
               if (mi_ff == span_max) begin
                  mk_in    = '0;
                  state_in = S_DEN;
               end else begin
                  mi_in    = mi_ff + WIN_W'(1);
                  state_in = S_ROW;
               end
            end else begin
               ni_in = ni_ff + WIN_W'(1);
               if (next_cc != cc_ff) begin
                  cc_in    = next_cc;
                  fcol_in  = next_cc + CW'(1);
                  fleft_in = 2'd1;
                  fk_in    = '0;
                  state_in = S_FETCH;
               end else begin
                  state_in = S_CALC;
               end
            end
         end
         S_DEN: begin
            den_in   = DEN_W'(lte_pkg::MASK_DSQ[mk_ff]) * DEN_W'(w2_ff);
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (mk_ff == lte_pkg::MASK_IDX_W'(lte_pkg::NUM_MASKS - 1)) begin
                  state_in = S_OUT;
               end else begin
                  mk_in    = mk_ff + lte_pkg::MASK_IDX_W'(1);
                  state_in = S_DEN;
               end
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      row_ff   <= row_in;
      col_ff   <= col_in;
      span_ff  <= span_in;
      w2_ff    <= w2_in;
      mi_ff    <= mi_in;
      ni_ff    <= ni_in;
      rr_ff    <= rr_in;
      cc_ff    <= cc_in;
      fcol_ff  <= fcol_in;
      fleft_ff <= fleft_in;
      fk_ff    <= fk_in;
      mk_ff    <= mk_in;
      den_ff   <= den_in;
   end

   // quotient capture, low field bits kept
   always_ff @(posedge clock) begin
      if (state_ff == S_DIV && div_done) begin
         res_ff[mk_ff] <= div_quot[lte_pkg::ENERGY_W-1:0];
      end
   end

   // result beat assembly
   always_comb begin
      rsp_beat.energy_0 = res_ff[0];
      rsp_beat.energy_1 = res_ff[1];
      rsp_beat.energy_2 = res_ff[2];
      rsp_beat.energy_3 = res_ff[3];
      rsp_beat.energy_4 = res_ff[4];
      rsp_beat.energy_5 = res_ff[5];
      rsp_beat.energy_6 = res_ff[6];
      rsp_beat.energy_7 = res_ff[7];
      rsp_beat.energy_8 = res_ff[8];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_beat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lte_frame_mem u_mem (
      .clock   (clock),
      .wr_en   (write_take),
      .wr_addr ({req_data.row, req_data.col}),
      .wr_data (req_data.pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lte_mask_acc #(
      .ACC_W (ACC_W)
   ) u_acc (
      .clock   (clock),
      .ctl     (ctl),
      .rd_data (rd_data),
      .acc     (acc)
   );

   lte_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({acc[mk_ff], 8'd0}),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer and output checks
   assert property (@(posedge clock) disable iff (reset) query_take |=> state_ff != S_IDLE)
      else $error("query beat did not start a walk");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output state");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished result not moved to the output register");
   assert property (@(posedge clock) disable iff (reset)
      write_take |=> state_ff == S_IDLE)
      else $error("pixel write left the idle state");

endmodule
